FILE: rtl/core/sgckc_pkg.sv
// shared types and codes for the stick gesture camera key controller
package sgckc_pkg;

   // stick sample and threshold width
   localparam int unsigned STICK_W = 12;

   // request kinds carried in req_tuser
   localparam logic OP_TICK     = 1'b0;
   localparam logic OP_RESPONSE = 1'b1;

   // result kinds carried in rsp_tuser
   localparam logic [1:0] KIND_BUTTON = 2'd0;
   localparam logic [1:0] KIND_KEY    = 2'd1;
   localparam logic [1:0] KIND_BEEP   = 2'd2;

   // key event codes: the five-key pad, open, close and release
   localparam logic [2:0] KEY_LEFT    = 3'd0;
   localparam logic [2:0] KEY_UP      = 3'd1;
   localparam logic [2:0] KEY_RIGHT   = 3'd2;
   localparam logic [2:0] KEY_DOWN    = 3'd3;
   localparam logic [2:0] KEY_ENTER   = 3'd4;
   localparam logic [2:0] KEY_OPEN    = 3'd5;
   localparam logic [2:0] KEY_CLOSE   = 3'd6;
   localparam logic [2:0] KEY_RELEASE = 3'd7;

   // beep codes
   localparam logic [2:0] BEEP_OPEN  = 3'd0;
   localparam logic [2:0] BEEP_CLOSE = 3'd1;

   // device response commands
   localparam logic [1:0] CMD_RELEASE = 2'd0;
   localparam logic [1:0] CMD_CONNECT = 2'd1;
   localparam logic [1:0] CMD_PRESS   = 2'd2;

   // connection operations
   localparam logic CONN_OPEN  = 1'b0;

   // result code bits that mean done
   localparam logic [3:0] CODE_MASK = 4'hF;

   // control register indexes
   localparam logic [2:0] CSR_STICK_HIGH = 3'd0;
   localparam logic [2:0] CSR_STICK_LOW  = 3'd1;
   localparam logic [2:0] CSR_MID_START  = 3'd2;
   localparam logic [2:0] CSR_MID_END    = 3'd3;
   localparam logic [2:0] CSR_FEATURE    = 3'd4;

   // control register reset values
   localparam logic [STICK_W-1:0] STICK_HIGH_RST = 12'd1920;
   localparam logic [STICK_W-1:0] STICK_LOW_RST  = 12'd1080;
   localparam logic [STICK_W-1:0] MID_START_RST  = 12'd1350;
   localparam logic [STICK_W-1:0] MID_END_RST    = 12'd1650;
   localparam logic [2:0]         FEATURE_RST    = 3'd0;

   // most results one request can cause
   localparam int unsigned MAX_RESULTS = 4;

   // one unpacked request
   typedef struct packed {
      logic               opcode;
      logic [STICK_W-1:0] throttle_stick;
      logic [STICK_W-1:0] roll_stick;
      logic [STICK_W-1:0] pitch_stick;
      logic [STICK_W-1:0] yaw_stick;
      logic [3:0]         status_flags;
      logic [2:0]         camera_switches;
      logic               resp_ok;
      logic [1:0]         resp_command;
      logic               resp_operation;
      logic [3:0]         resp_code;
   } req_item_type;

   // one result entry
   typedef struct packed {
      logic [1:0] kind;
      logic [2:0] code;
   } result_type;

endpackage

FILE: rtl/core/stick_gesture_camera_key_controller_core.sv
// stick gesture camera key controller: request register, decode logic and result buffer
//
// channel  dir  handshake              payload
// req      in   req_tvalid/req_tready  req_tdata (64b), req_tuser (opcode)
// rsp      out  rsp_tvalid/rsp_tready  rsp_tdata (8b), rsp_tuser (kind), rsp_tlast
// csr      in   csr_valid/csr_ready    csr_index (3b), csr_data (12b)
//
// a request is decoded from the request register into the result buffer; the buffer drains
// one result per cycle while rsp_tready is high, up to four results per request, and the
// next request is taken while results are still drained. the first result is valid once the
// request has been registered and then decoded, which waits until the buffer is free.
// reset empties the request register and result buffer, loads the control register
// defaults and sets the switch latches.
// csr writes are always taken; rsp_tready low holds the buffer and backs up into req_tready.
module stick_gesture_camera_key_controller_core
   import sgckc_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   // request channel
   input  logic        req_tvalid,
   output logic        req_tready,
   // [11:0] throttle_stick, [23:12] roll_stick, [35:24] pitch_stick, [47:36] yaw_stick,
   // [51:48] status_flags, [54:52] camera_switches, [55] resp_ok, [57:56] resp_command,
   // [58] resp_operation, [62:59] resp_code, [63] zero
   input  logic [63:0] req_tdata,
   // [0] opcode
   input  logic        req_tuser,
   // result channel
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   // [2:0] out_code, [7:3] zero
   output logic [7:0]  rsp_tdata,
   // [1:0] out_kind
   output logic [1:0]  rsp_tuser,
   output logic        rsp_tlast,
   // control register write channel
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [2:0]  csr_index,
   input  logic [11:0] csr_data
);

   // control registers
   logic [STICK_W-1:0] stick_high_ff;
   logic [STICK_W-1:0] stick_low_ff;
   logic [STICK_W-1:0] mid_start_ff;
   logic [STICK_W-1:0] mid_end_ff;
   logic [2:0]         feature_ff;

   // request register
   logic               item_valid_ff;
   req_item_type       item_ff;

   // controller state
   logic [2:0]         latch_ff, latch_in;
   logic               pressed_ff, pressed_in;
   logic               waiting_ff, waiting_in;
   logic               menu_ff, menu_in;

   // result buffer
   result_type         buf_ff [MAX_RESULTS];
   result_type         buf_in [MAX_RESULTS];
   logic [2:0]         rem_ff;
   logic [1:0]         rd_ff;
   logic [2:0]         count_in;

   logic               buf_free;
   logic               decode;
   logic               rsp_pop;

   // stick classes
   logic thr_mid, roll_mid, pitch_mid, yaw_mid;
   logic roll_lo, pitch_lo, yaw_lo, roll_hi, pitch_hi, yaw_hi;
   logic centered, key_fire, safe, done;
   logic [2:0] key_code;
   logic [2:0] fire;

   assign csr_ready = 1'b1;

   // control register writes
   always_ff @(posedge clock) begin
      if (reset) begin
         stick_high_ff <= STICK_HIGH_RST;
         stick_low_ff  <= STICK_LOW_RST;
         mid_start_ff  <= MID_START_RST;
         mid_end_ff    <= MID_END_RST;
         feature_ff    <= FEATURE_RST;
      end else if (csr_valid) begin
         unique case (csr_index)
            CSR_STICK_HIGH: stick_high_ff <= csr_data;
            CSR_STICK_LOW:  stick_low_ff  <= csr_data;
            CSR_MID_START:  mid_start_ff  <= csr_data;
            CSR_MID_END:    mid_end_ff    <= csr_data;
            CSR_FEATURE:    feature_ff    <= csr_data[2:0];
            default: ;
         endcase
      end
   end

   // handshake control
   assign rsp_tvalid = (rem_ff != 3'd0);
   assign rsp_pop    = rsp_tvalid && rsp_tready;
   assign buf_free   = (rem_ff == 3'd0) || ((rem_ff == 3'd1) && rsp_tready);
   assign decode     = item_valid_ff && buf_free;
   assign req_tready = !item_valid_ff || decode;

   // request register
   always_ff @(posedge clock) begin
      if (reset) begin
         item_valid_ff <= 1'b0;
      end else if (req_tready) begin
         item_valid_ff <= req_tvalid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_tvalid && req_tready) begin
         item_ff.opcode          <= req_tuser;
         item_ff.throttle_stick  <= req_tdata[11:0];
         item_ff.roll_stick      <= req_tdata[23:12];
         item_ff.pitch_stick     <= req_tdata[35:24];
         item_ff.yaw_stick       <= req_tdata[47:36];
         item_ff.status_flags    <= req_tdata[51:48];
         item_ff.camera_switches <= req_tdata[54:52];
         item_ff.resp_ok         <= req_tdata[55];
         item_ff.resp_command    <= req_tdata[57:56];
         item_ff.resp_operation  <= req_tdata[58];
         item_ff.resp_code       <= req_tdata[62:59];
      end
   end

   // stick classification
   assign thr_mid   = (item_ff.throttle_stick > mid_start_ff) &&
                      (item_ff.throttle_stick < mid_end_ff);
   assign roll_mid  = (item_ff.roll_stick > mid_start_ff) && (item_ff.roll_stick < mid_end_ff);
   assign pitch_mid = (item_ff.pitch_stick > mid_start_ff) && (item_ff.pitch_stick < mid_end_ff);
   assign yaw_mid   = (item_ff.yaw_stick > mid_start_ff) && (item_ff.yaw_stick < mid_end_ff);
   assign roll_lo   = item_ff.roll_stick < stick_low_ff;
   assign pitch_lo  = item_ff.pitch_stick < stick_low_ff;
   assign yaw_lo    = item_ff.yaw_stick < stick_low_ff;
   assign roll_hi   = item_ff.roll_stick > stick_high_ff;
   assign pitch_hi  = item_ff.pitch_stick > stick_high_ff;
   assign yaw_hi    = item_ff.yaw_stick > stick_high_ff;
   assign centered  = thr_mid && roll_mid && pitch_mid;
   assign safe      = !item_ff.status_flags[0] && !item_ff.status_flags[1];
   assign done      = (item_ff.resp_code & CODE_MASK) != 4'd0;

   // camera button firing per switch; the power button ignores arming
   always_comb begin
      for (int i = 0; i < 3; i++) begin
         fire[i] = item_ff.camera_switches[i] && !latch_ff[i] && feature_ff[i]
                   && ((i == 1) || safe);
      end
   end

   // five key selection when idle and not pressed
   always_comb begin
      key_fire = 1'b0;
      key_code = KEY_LEFT;
      if (centered && yaw_lo) begin
         key_fire = menu_ff;
         key_code = KEY_CLOSE;
      end else if (menu_ff) begin
         key_fire = 1'b1;
         if (roll_lo) begin
            key_code = KEY_LEFT;
         end else if (pitch_hi) begin
            key_code = KEY_UP;
         end else if (roll_hi) begin
            key_code = KEY_RIGHT;
         end else if (pitch_lo) begin
            key_code = KEY_DOWN;
         end else if (centered && yaw_hi) begin
            key_code = KEY_ENTER;
         end else begin
            key_fire = 1'b0;
         end
      end else if (centered && yaw_hi) begin
         key_fire = 1'b1;
         key_code = KEY_OPEN;
      end
   end

   // result list and next state for the request in the register
   always_comb begin
      latch_in   = latch_ff;
      pressed_in = pressed_ff;
      waiting_in = waiting_ff;
      menu_in    = menu_ff;
      count_in   = 3'd0;
      for (int j = 0; j < MAX_RESULTS; j++) begin
         buf_in[j] = buf_ff[j];
      end
      if (item_ff.opcode == OP_RESPONSE) begin
         if (item_ff.resp_ok) begin
            unique case (item_ff.resp_command)
               CMD_RELEASE: pressed_in = 1'b0;
               CMD_PRESS:   pressed_in = 1'b1;
               CMD_CONNECT: begin
                  pressed_in = 1'b1;
                  if (item_ff.resp_operation == CONN_OPEN) begin
                     buf_in[0] = '{kind: KIND_BEEP, code: done ? BEEP_OPEN : BEEP_CLOSE};
                     count_in  = 3'd1;
                     if (done) begin
                        menu_in = 1'b1;
                     end
                  end else if (done) begin
                     menu_in   = 1'b0;
                     buf_in[0] = '{kind: KIND_BEEP, code: BEEP_CLOSE};
                     count_in  = 3'd1;
                  end
               end
               default: ;
            endcase
         end
         waiting_in = 1'b0;
      end else begin
         // camera buttons in switch order
         for (int i = 0; i < 3; i++) begin
            if (item_ff.camera_switches[i]) begin
               if (fire[i]) begin
                  buf_in[count_in[1:0]] = '{kind: KIND_BUTTON, code: 3'(i)};
                  count_in    = count_in + 3'd1;
                  latch_in[i] = 1'b1;
               end
            end else begin
               latch_in[i] = 1'b0;
            end
         end
         // stick gesture event
         if (item_ff.status_flags == 4'd0) begin
            if (pressed_ff) begin
               if (yaw_mid && pitch_mid && roll_mid) begin
                  buf_in[count_in[1:0]] = '{kind: KIND_KEY, code: KEY_RELEASE};
                  count_in   = count_in + 3'd1;
                  waiting_in = 1'b1;
               end
            end else if (!waiting_ff && key_fire) begin
               buf_in[count_in[1:0]] = '{kind: KIND_KEY, code: key_code};
               count_in   = count_in + 3'd1;
               pressed_in = 1'b1;
               waiting_in = 1'b1;
            end
         end
      end
   end

   // controller state update
   always_ff @(posedge clock) begin
      if (reset) begin
         latch_ff   <= 3'b111;
         pressed_ff <= 1'b0;
         waiting_ff <= 1'b0;
         menu_ff    <= 1'b0;
      end else if (decode) begin
         latch_ff   <= latch_in;
         pressed_ff <= pressed_in;
         waiting_ff <= waiting_in;
         menu_ff    <= menu_in;
      end
   end

   // result buffer load and drain
   always_ff @(posedge clock) begin
      if (reset) begin
         rem_ff <= 3'd0;
         rd_ff  <= 2'd0;
      end else if (decode) begin
         rem_ff <= count_in;
         rd_ff  <= 2'd0;
      end else if (rsp_pop) begin
         rem_ff <= rem_ff - 3'd1;
         rd_ff  <= rd_ff + 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (decode) begin
         for (int j = 0; j < MAX_RESULTS; j++) begin
            buf_ff[j] <= buf_in[j];
         end
      end
   end

   // result channel payload
   assign rsp_tuser = buf_ff[rd_ff].kind;
   assign rsp_tdata = {5'd0, buf_ff[rd_ff].code};
   assign rsp_tlast = (rem_ff == 3'd1);

endmodule
